### hw/rtl/tdp_pkg.sv
// Shared types and constants for the trial-division prime test.
// Used by tdp_ctrl, tdp_dpath and trial_division_prime_test.
`default_nettype none

package tdp_pkg;

  // Operand width (two's complement input)
  localparam int DATA_WIDTH = 32;
  // Magnitude bits of a non-negative operand
  localparam int MAG_W      = DATA_WIDTH - 1;
  // Divisor width: trial divisors never exceed floor(sqrt(value)) + 1
  localparam int DIV_W      = DATA_WIDTH / 2 + 1;
  // Running square of the divisor
  localparam int SQ_W       = 2 * DIV_W;
  // Bit index into the magnitude during the remainder pass
  localparam int IDX_W      = $clog2(MAG_W);

  // Smallest prime, and the first trial divisor
  localparam int FIRST_DIV  = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_BOUND,
    ST_DIV,
    ST_TEST,
    ST_RESULT
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;        // capture the operand
    logic init;        // divisor = 2, square = 4
    logic div_start;   // clear remainder, point at the top magnitude bit
    logic div_step;    // one restoring-remainder step
    logic advance;     // next divisor, update square
    logic verdict_we;  // write verdict
    logic verdict_val;
    logic out_load;    // move verdict into the output register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic trivial;     // negative, zero or one
    logic bound_over;  // divisor squared exceeds the operand
    logic div_last;    // remainder step on bit 0
    logic rem_zero;    // divisor divides the operand
    logic out_free;    // output register can take a result
  } status_t;

endpackage

`default_nettype wire

### hw/rtl/tdp_dpath.sv
// Datapath of the prime test: operand, divisor, running square, bit-serial
// remainder unit and output register. Depends on tdp_pkg.
`default_nettype none

module tdp_dpath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [tdp_pkg::DATA_WIDTH-1:0]  value,
  input  wire tdp_pkg::cmd_t                   cmd,
  output tdp_pkg::status_t                     status,
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output logic                                 is_prime
);
  import tdp_pkg::*;

  logic [DATA_WIDTH-1:0] v;
  logic [DIV_W-1:0]      d;
  logic [SQ_W-1:0]       sq;
  logic [DIV_W-1:0]      rem;
  logic [IDX_W-1:0]      idx;
  logic                  verdict;

  logic [DIV_W:0]        shifted;
  logic [DIV_W:0]        diff;
  logic [DIV_W-1:0]      rem_next;
  logic [SQ_W-1:0]       v_ext;

  // Restoring remainder step: bring in one operand bit, subtract if it fits
  always_comb begin
    shifted  = {rem, v[idx]};
    diff     = shifted - {1'b0, d};
    rem_next = (shifted >= {1'b0, d}) ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
  end

  assign v_ext = {{(SQ_W - MAG_W){1'b0}}, v[MAG_W-1:0]};

  // Status toward the controller
  always_comb begin
    status.trivial    = v[DATA_WIDTH-1] || (v < DATA_WIDTH'(FIRST_DIV));
    status.bound_over = sq > v_ext;
    status.div_last   = (idx == '0);
    status.rem_zero   = (rem == '0);
    status.out_free   = !out_valid || out_ready;
  end

  // Operand, divisor and square
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v <= value;
    end
    if (cmd.init) begin
      d  <= DIV_W'(FIRST_DIV);
      sq <= SQ_W'(FIRST_DIV * FIRST_DIV);
    end else if (cmd.advance) begin
      // (d+1)^2 = d^2 + 2d + 1
      d  <= d + 1'b1;
      sq <= sq + {{(SQ_W - DIV_W - 1){1'b0}}, d, 1'b1};
    end
  end

  // Remainder unit
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem <= '0;
      idx <= IDX_W'(MAG_W - 1);
    end else if (cmd.div_step) begin
      rem <= rem_next;
      idx <= idx - 1'b1;
    end
  end

  // Verdict holding register
  always_ff @(posedge clk) begin
    if (cmd.verdict_we) begin
      verdict <= cmd.verdict_val;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      is_prime <= verdict;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/tdp_ctrl.sv
// Controller state machine of the prime test: sequences the bound check,
// the remainder passes and the result handoff. Depends on tdp_pkg.
`default_nettype none

module tdp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tdp_pkg::status_t  status,
  output tdp_pkg::cmd_t          cmd,
  output tdp_pkg::state_t        state
);
  import tdp_pkg::*;

  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_START;
      ST_START:  state_next = status.trivial ? ST_RESULT : ST_BOUND;
      ST_BOUND:  state_next = status.bound_over ? ST_RESULT : ST_DIV;
      ST_DIV:    if (status.div_last) state_next = ST_TEST;
      ST_TEST:   state_next = status.rem_zero ? ST_RESULT : ST_BOUND;
      ST_RESULT: if (status.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_START: begin
        if (status.trivial) begin
          cmd.verdict_we  = 1'b1;
          cmd.verdict_val = 1'b0;
        end else begin
          cmd.init = 1'b1;
        end
      end
      ST_BOUND: begin
        if (status.bound_over) begin
          cmd.verdict_we  = 1'b1;
          cmd.verdict_val = 1'b1;
        end else begin
          cmd.div_start = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_TEST: begin
        if (status.rem_zero) begin
          cmd.verdict_we  = 1'b1;
          cmd.verdict_val = 1'b0;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      ST_RESULT: begin
        cmd.out_load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/trial_division_prime_test.sv
// Trial-division primality test, one 32-bit signed value per transaction.
// One transaction in gives one is_prime out. Negative values, zero and one
// are reported not prime. Otherwise divisors d = 2, 3, ... are tried while
// d*d <= value; each divisor takes one bound check, a 31-step bit-serial
// remainder pass and one test, all on the shared remainder unit. One item
// is worked at a time; a finished result sits in an output register, and
// the next item is accepted while it waits. Depends on tdp_pkg, tdp_ctrl
// and tdp_dpath.
`default_nettype none

module trial_division_prime_test (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [tdp_pkg::DATA_WIDTH-1:0]  value,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 is_prime
);
  import tdp_pkg::*;

  cmd_t    cmd;
  status_t status;
  state_t  state;

  tdp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd),
    .state    (state)
  );

  tdp_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .is_prime  (is_prime)
  );

  // Busy right after an accepted transaction
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted a transaction while busy");

  // A negative operand goes straight to the result
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && value[DATA_WIDTH-1]) |-> ##2 (state == ST_RESULT))
    else $error("negative operand not short-circuited");

  // Never overwrite a result that has not been taken
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("output register overwritten");

  // A zero remainder ends the search
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_TEST && status.rem_zero) |=> (state == ST_RESULT))
    else $error("divisor found but search continued");

endmodule

`default_nettype wire

### sim/tb_trial_division_prime_test.sv
`timescale 1ns / 100ps
// Testbench for trial_division_prime_test: streams signed values through the block and
// checks each is_prime verdict against a local trial-division predictor.
// Depends on tdp_pkg and the trial_division_prime_test RTL.

module tb_trial_division_prime_test;

  localparam int W = tdp_pkg::DATA_WIDTH;
  localparam int RANDOM_PER_PHASE = 20;
  // Slowest correct run: 2^31-1 alone, plus a random part in which every
  // value drawn is a prime just below 2^22; this limit is a few times over that.
  localparam int LIMIT_CYCLES = 30_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [W-1:0] value;
    logic         verdict;
  } verdict_t;

  logic         clk;
  logic         rst;
  logic         in_valid;
  logic         in_ready;
  logic [W-1:0] value;
  logic         out_valid;
  logic         out_ready = 1'b0;
  logic         is_prime;

  verdict_t     pending_verdicts[$];
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;
  int unsigned  src_idle_pct;
  int unsigned  sink_stall_pct;

  trial_division_prime_test dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .is_prime  (is_prime)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Trial division with the bound kept as d <= v / d
  function automatic logic prime_verdict(input logic [W-1:0] raw);
    longint unsigned v;
    longint unsigned d;
    v = raw;
    if (raw[W-1]) return 1'b0;
    if (v < 2) return 1'b0;
    for (d = 2; d <= v / d; d++) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Send one value; an optional idle stretch comes first
  task automatic send_value(input logic [W-1:0] v);
    verdict_t entry;
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      value    <= $urandom();
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    entry.value   = v;
    entry.verdict = prime_verdict(v);
    pending_verdicts.push_back(entry);
  endtask

  // Result side: random stall and verdict compare
  always @(posedge clk) begin
    verdict_t entry;
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
    if (!rst && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        note_mismatch($sformatf("unexpected transaction, is_prime=%b", is_prime));
      end else begin
        entry = pending_verdicts.pop_front();
        if (is_prime !== entry.verdict)
          note_mismatch($sformatf("value=%0d expected is_prime=%b actual=%b",
                                  $signed(entry.value), entry.verdict, is_prime));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** trial_division_prime_test: FAILED **");
      $finish;
    end
  end

  // Negatives, zero and one: all report not prime
  task automatic test_below_two();
    send_value(32'h8000_0000);
    send_value(32'h8000_0001);
    send_value(-32'sd1);
    send_value(-32'sd7);
    send_value(32'd0);
    send_value(32'd1);
  endtask

  // Small primes, composites and prime squares
  task automatic test_small_values();
    send_value(32'd2);
    send_value(32'd3);
    send_value(32'd4);
    send_value(32'd5);
    send_value(32'd9);
    send_value(32'd25);
    send_value(32'd49);
    send_value(32'd97);
    send_value(32'd63001);
    send_value(32'd65521);
    send_value(32'd65537);
  endtask

  // Wide positive values that fall to a small divisor
  task automatic test_wide_composites();
    send_value(32'h4000_0000);
    send_value(32'h5555_5555);
    send_value(32'h2AAA_AAAA);
    send_value(32'h7FFF_FFFE);
  endtask

  // 2^31-1 is prime: the full divisor sweep right at the top of the range
  task automatic test_largest_positive();
    send_value(32'h7FFF_FFFF);
  endtask

  // Random mix; large primes are kept rare since each costs sqrt(v) passes
  task automatic test_random(input int unsigned src_pct, input int unsigned sink_pct);
    int unsigned  pick;
    int unsigned  k;
    logic [W-1:0] v;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    repeat (RANDOM_PER_PHASE) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        v = $urandom() | 32'h8000_0000;
      end else if (pick < 35) begin
        v = $urandom_range(3);
      end else if (pick < 50) begin
        // multiple of a small prime across the full positive width
        case ($urandom_range(3))
          0: k = 2;
          1: k = 3;
          2: k = 5;
          default: k = 7;
        endcase
        v = $urandom_range(32'h7FFF_FFFF / k, 1) * k;
      end else if (pick < 90) begin
        v = $urandom_range(65535, 2);
      end else begin
        v = $urandom_range(32'h003F_FFFF, 65536);
      end
      send_value(v);
    end
  endtask

  // Main sequence
  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    value          = '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_below_two();
    test_small_values();
    test_wide_composites();
    test_largest_positive();
    test_random(0, 0);
    test_random(86, 0);
    test_random(0, 86);
    test_random(35, 35);

    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("** trial_division_prime_test: PASSED **");
    else
      $display("** trial_division_prime_test: FAILED **");
    $finish;
  end

endmodule
